/* hdl/rgbbmf_pkg.sv */
// Shared types and constants for the RGB box mean filter.
`default_nettype none
package rgbbmf_pkg;

  localparam int CFG_DW = 11;
  localparam int CFG_IW = 2;

  localparam logic [CFG_IW-1:0] REG_RADIUS = 2'd0;
  localparam logic [CFG_IW-1:0] REG_WIDTH  = 2'd1;
  localparam logic [CFG_IW-1:0] REG_HEIGHT = 2'd2;

  localparam logic [3:0]  RADIUS_RESET = 4'd1;
  localparam logic [10:0] WIDTH_RESET  = 11'd640;
  localparam logic [10:0] HEIGHT_RESET = 11'd480;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  localparam int QW = 8;

  typedef struct packed {
    logic       operation;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
  } pix_in_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic       frame_done;
  } pix_out_t;

  typedef struct packed {
    logic accept;
    logic win_step;
    logic div_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic emit;
    logic win_last;
    logic div_last;
    logic out_free;
  } status_t;

endpackage
`default_nettype wire

/* hdl/rgbbmf_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module rgbbmf_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 20480
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

/* hdl/rgbbmf_ctrl.sv */
// Controller state machine sequencing window reads, division and output.
`default_nettype none
module rgbbmf_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               src_valid,
  output logic                    src_ready,
  input  wire rgbbmf_pkg::status_t status,
  output rgbbmf_pkg::cmd_t        cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_WIN   = 3'd1;
  localparam logic [2:0] S_FLUSH = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  assign src_ready = (state == S_IDLE);

  always_comb begin
    state_next   = state;
    cmd          = '0;
    unique case (state)
      S_IDLE: begin
        cmd.accept = src_valid;
        if (src_valid && status.emit) begin
          state_next = S_WIN;
        end
      end
      S_WIN: begin
        cmd.win_step = 1'b1;
        if (status.win_last) begin
          state_next = S_FLUSH;
        end
      end
      S_FLUSH: begin
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.accept, cmd.win_step, cmd.div_step, cmd.out_load}))
    else $error("overlapping datapath commands");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> status.out_free)
    else $error("output register overwritten");

  a_flush_after_win: assert property (@(posedge clk) disable iff (rst)
    state == S_FLUSH |-> $past(state) == S_WIN)
    else $error("flush without window pass");

  a_div_to_out: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV && status.div_last) |=> state == S_OUT)
    else $error("divide did not finish into output");

endmodule
`default_nettype wire

/* hdl/rgbbmf_dp.sv */
// Datapath: config, position counters, line store, window sum, divider, output register.
`default_nettype none
module rgbbmf_dp #(
  parameter int MAX_RADIUS = 9,
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [rgbbmf_pkg::CFG_IW-1:0]   cfg_index,
  input  wire logic [rgbbmf_pkg::CFG_DW-1:0]   cfg_data,
  input  wire rgbbmf_pkg::pix_in_t             src_data,
  output rgbbmf_pkg::pix_out_t                 dst_data,
  output logic                                 dst_valid,
  input  wire logic                            dst_ready,
  input  wire rgbbmf_pkg::cmd_t                cmd,
  output rgbbmf_pkg::status_t                  status
);

  localparam int RING = 2 * MAX_RADIUS + 2;
  localparam int RGW  = $clog2(RING);
  localparam int XW   = $clog2(MAX_WIDTH);
  localparam int YW   = $clog2(MAX_HEIGHT);
  localparam int WW   = $clog2(MAX_WIDTH + 1);
  localparam int HW   = $clog2(MAX_HEIGHT + 1);
  localparam int RW   = $clog2(MAX_RADIUS + 1);
  localparam int CW   = $clog2(2 * MAX_RADIUS + 1);
  localparam int AW   = $clog2(RING * MAX_WIDTH);
  localparam int IDXW = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
  localparam int ACCW = $clog2((2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1) * 255 + 1);
  localparam int SW   = ((XW > YW) ? XW : YW) + 2;
  localparam int ARW  = 2 * (RW + 1);

  // configuration
  logic [3:0]  radius;
  logic [10:0] frame_width;
  logic [10:0] frame_height;
  logic        cfg_hit;

  logic [RW-1:0] r;
  logic [WW-1:0] w;
  logic [HW-1:0] h;

  assign r = (32'(radius) > MAX_RADIUS) ? RW'(MAX_RADIUS) : RW'(radius);
  assign w = (frame_width == 11'd0) ? WW'(1) :
             (32'(frame_width) > MAX_WIDTH) ? WW'(MAX_WIDTH) : WW'(frame_width);
  assign h = (frame_height == 11'd0) ? HW'(1) :
             (32'(frame_height) > MAX_HEIGHT) ? HW'(MAX_HEIGHT) : HW'(frame_height);

  assign cfg_hit = cfg_we && (cfg_index == rgbbmf_pkg::REG_RADIUS ||
                              cfg_index == rgbbmf_pkg::REG_WIDTH ||
                              cfg_index == rgbbmf_pkg::REG_HEIGHT);

  // position counters
  logic [XW-1:0]   in_col;
  logic [HW-1:0]   in_row;
  logic [RGW-1:0]  in_ring;
  logic [IDXW-1:0] in_idx;
  logic [XW-1:0]   out_col;
  logic [YW-1:0]   out_row;
  logic [RGW-1:0]  out_ring;

  logic        full;
  logic [31:0] lag;
  logic        is_pixel;
  logic        pix_write;
  logic        win_start;
  logic        done_now;

  assign full     = (in_row >= h);
  assign lag      = 32'(r) * 32'(w) +
                    ((32'(r) < 32'(w) - 32'd1) ? 32'(r) : 32'(w) - 32'd1);
  assign is_pixel = (src_data.operation == rgbbmf_pkg::OP_PIXEL);
  assign status.emit = is_pixel ? (!full && (32'(in_idx) >= lag)) : full;
  assign pix_write = cmd.accept && is_pixel && !full;
  assign win_start = cmd.accept && status.emit;
  assign done_now  = (32'(out_row) >= 32'(h) - 32'd1) && (32'(out_col) >= 32'(w) - 32'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      radius       <= rgbbmf_pkg::RADIUS_RESET;
      frame_width  <= rgbbmf_pkg::WIDTH_RESET;
      frame_height <= rgbbmf_pkg::HEIGHT_RESET;
      in_col   <= '0;
      in_row   <= '0;
      in_ring  <= '0;
      in_idx   <= '0;
      out_col  <= '0;
      out_row  <= '0;
      out_ring <= '0;
    end else if (cfg_hit) begin
      unique case (cfg_index)
        rgbbmf_pkg::REG_RADIUS: radius       <= cfg_data[3:0];
        rgbbmf_pkg::REG_WIDTH:  frame_width  <= cfg_data;
        rgbbmf_pkg::REG_HEIGHT: frame_height <= cfg_data;
        default: ;
      endcase
      in_col   <= '0;
      in_row   <= '0;
      in_ring  <= '0;
      in_idx   <= '0;
      out_col  <= '0;
      out_row  <= '0;
      out_ring <= '0;
    end else if (win_start && done_now) begin
      in_col   <= '0;
      in_row   <= '0;
      in_ring  <= '0;
      in_idx   <= '0;
      out_col  <= '0;
      out_row  <= '0;
      out_ring <= '0;
    end else begin
      if (pix_write) begin
        in_idx <= in_idx + IDXW'(1);
        if (32'(in_col) + 32'd1 >= 32'(w)) begin
          in_col  <= '0;
          in_row  <= in_row + HW'(1);
          in_ring <= (32'(in_ring) == RING - 1) ? '0 : in_ring + RGW'(1);
        end else begin
          in_col <= in_col + XW'(1);
        end
      end
      if (win_start) begin
        if (32'(out_col) + 32'd1 >= 32'(w)) begin
          out_col  <= '0;
          out_row  <= out_row + YW'(1);
          out_ring <= (32'(out_ring) == RING - 1) ? '0 : out_ring + RGW'(1);
        end else begin
          out_col <= out_col + XW'(1);
        end
      end
    end
  end

  // window walk
  logic signed [SW-1:0] wy_u;
  logic signed [SW-1:0] wx_u;
  logic signed [SW-1:0] wx_u0;
  logic [RGW-1:0]       wy_ring;
  logic [XW-1:0]        wx_c;
  logic [XW-1:0]        wx_c0;
  logic [CW-1:0]        cy;
  logic [CW-1:0]        cx;
  logic                 done_flag;
  logic                 rd_pend;
  logic [CW-1:0]        span;
  logic                 row_end;
  logic                 y_move;
  logic                 x_move;

  assign span    = CW'({r, 1'b0});
  assign row_end = (cx == span);
  assign status.win_last = row_end && (cy == span);
  assign y_move = (wy_u >= 0) && (wy_u < $signed(SW'(h - HW'(1))));
  assign x_move = (wx_u >= 0) && (wx_u < $signed(SW'(w - WW'(1))));

  always_ff @(posedge clk) begin
    if (win_start) begin
      wy_u  <= $signed(SW'(out_row)) - $signed(SW'(r));
      wx_u  <= $signed(SW'(out_col)) - $signed(SW'(r));
      wx_u0 <= $signed(SW'(out_col)) - $signed(SW'(r));
      wx_c  <= (out_col >= XW'(r)) ? out_col - XW'(r) : '0;
      wx_c0 <= (out_col >= XW'(r)) ? out_col - XW'(r) : '0;
      if (out_row >= YW'(r)) begin
        wy_ring <= (out_ring >= RGW'(r)) ? out_ring - RGW'(r) :
                   out_ring + RGW'(RING) - RGW'(r);
      end else begin
        wy_ring <= '0;
      end
      cy        <= '0;
      cx        <= '0;
      done_flag <= done_now;
    end else if (cmd.win_step) begin
      if (row_end) begin
        cx   <= '0;
        cy   <= cy + CW'(1);
        wx_u <= wx_u0;
        wx_c <= wx_c0;
        wy_u <= wy_u + SW'(1);
        if (y_move) begin
          wy_ring <= (32'(wy_ring) == RING - 1) ? '0 : wy_ring + RGW'(1);
        end
      end else begin
        cx   <= cx + CW'(1);
        wx_u <= wx_u + SW'(1);
        if (x_move) begin
          wx_c <= wx_c + XW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend <= 1'b0;
    end else begin
      rd_pend <= cmd.win_step;
    end
  end

  // line store
  logic [AW-1:0] waddr;
  logic [AW-1:0] raddr;
  logic [23:0]   rdata;

  assign waddr = AW'(in_ring) * AW'(MAX_WIDTH) + AW'(in_col);
  assign raddr = AW'(wy_ring) * AW'(MAX_WIDTH) + AW'(wx_c);

  rgbbmf_ram #(
    .WIDTH (24),
    .DEPTH (RING * MAX_WIDTH)
  ) u_line_store (
    .clk   (clk),
    .we    (pix_write),
    .waddr (waddr),
    .wdata ({src_data.red_in, src_data.green_in, src_data.blue_in}),
    .re    (cmd.win_step),
    .raddr (raddr),
    .rdata (rdata)
  );

  // accumulate, then restoring divide by the window area
  logic [ACCW-1:0] acc_r;
  logic [ACCW-1:0] acc_g;
  logic [ACCW-1:0] acc_b;
  logic [ACCW-1:0] dshift;
  logic [rgbbmf_pkg::QW-1:0] q_r;
  logic [rgbbmf_pkg::QW-1:0] q_g;
  logic [rgbbmf_pkg::QW-1:0] q_b;
  logic [2:0]      div_cnt;
  logic [RW:0]     side;
  logic [ARW-1:0]  area;
  logic            ge_r;
  logic            ge_g;
  logic            ge_b;

  assign side = {r, 1'b1};
  assign area = ARW'(side) * ARW'(side);
  assign ge_r = (acc_r >= dshift);
  assign ge_g = (acc_g >= dshift);
  assign ge_b = (acc_b >= dshift);
  assign status.div_last = (div_cnt == 3'd7);

  always_ff @(posedge clk) begin
    if (win_start) begin
      acc_r   <= '0;
      acc_g   <= '0;
      acc_b   <= '0;
      dshift  <= ACCW'(area) << (rgbbmf_pkg::QW - 1);
      div_cnt <= '0;
    end else if (rd_pend) begin
      acc_r <= acc_r + ACCW'(rdata[23:16]);
      acc_g <= acc_g + ACCW'(rdata[15:8]);
      acc_b <= acc_b + ACCW'(rdata[7:0]);
    end else if (cmd.div_step) begin
      if (ge_r) acc_r <= acc_r - dshift;
      if (ge_g) acc_g <= acc_g - dshift;
      if (ge_b) acc_b <= acc_b - dshift;
      q_r     <= {q_r[rgbbmf_pkg::QW-2:0], ge_r};
      q_g     <= {q_g[rgbbmf_pkg::QW-2:0], ge_g};
      q_b     <= {q_b[rgbbmf_pkg::QW-2:0], ge_b};
      dshift  <= dshift >> 1;
      div_cnt <= div_cnt + 3'd1;
    end
  end

  // output register
  assign status.out_free = !dst_valid || dst_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dst_valid <= 1'b0;
    end else if (cmd.out_load) begin
      dst_valid <= 1'b1;
    end else if (dst_ready) begin
      dst_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      dst_data.red_out    <= q_r;
      dst_data.green_out  <= q_g;
      dst_data.blue_out   <= q_b;
      dst_data.frame_done <= done_flag;
    end
  end

  a_no_write_when_full: assert property (@(posedge clk) disable iff (rst)
    pix_write |-> !full)
    else $error("line store written past frame end");

  a_read_follows_step: assert property (@(posedge clk) disable iff (rst)
    cmd.win_step |=> rd_pend)
    else $error("window read not accumulated");

  a_ring_range: assert property (@(posedge clk) disable iff (rst)
    (32'(in_ring) < RING) && (32'(out_ring) < RING))
    else $error("ring row out of range");

endmodule
`default_nettype wire

/* hdl/rgb_box_mean_filter.sv */
// Top level of the streaming RGB box mean filter.
// An item that yields a word takes one line-store read per window pixel, a flush, eight divide
// steps and an output load, which waits while the output register is full; other items only get accepted.
// src_ready is high only in the idle state, so a new item is not taken until the previous one is through.
// Reset: synchronous, restores radius 1, 640 x 480 and clears the position counters; no clearing pass.
`default_nettype none
module rgb_box_mean_filter #(
  parameter int MAX_RADIUS = 9,
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [rgbbmf_pkg::CFG_IW-1:0] cfg_index,
  input  wire logic [rgbbmf_pkg::CFG_DW-1:0] cfg_data,
  input  wire logic                          src_valid,
  output logic                               src_ready,
  input  wire rgbbmf_pkg::pix_in_t           src_data,
  output logic                               dst_valid,
  input  wire logic                          dst_ready,
  output rgbbmf_pkg::pix_out_t               dst_data
);

  rgbbmf_pkg::cmd_t    cmd;
  rgbbmf_pkg::status_t status;

  rgbbmf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .src_valid (src_valid),
    .src_ready (src_ready),
    .status    (status),
    .cmd       (cmd)
  );

  rgbbmf_dp #(
    .MAX_RADIUS (MAX_RADIUS),
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .src_data  (src_data),
    .dst_data  (dst_data),
    .dst_valid (dst_valid),
    .dst_ready (dst_ready),
    .cmd       (cmd),
    .status    (status)
  );

endmodule
`default_nettype wire
